// ----- src/kmmma_pkg.sv -----
// Package of shared constants and types for the keyed min/max/mean aggregator.
package kmmma_pkg;
  localparam int HashSlots    = 4096;
  localparam int MaxEntries   = 512;
  localparam int MaxNameBytes = 128;
  localparam int HashW  = $clog2(HashSlots);
  localparam int EntW   = $clog2(MaxEntries);
  localparam int SlotW  = $clog2(MaxEntries + 1);
  localparam int NameW  = $clog2(MaxNameBytes);
  localparam int LenW   = $clog2(MaxNameBytes + 2);
  localparam int ProbeW = $clog2(HashSlots + 1);

  localparam logic [1:0] StUpdated = 2'd0;
  localparam logic [1:0] StNew     = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;
  localparam logic [1:0] StLong    = 2'd3;

  localparam logic [7:0] ChNl    = 8'd10;
  localparam logic [7:0] ChSemi  = 8'h3b;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic signed [47:0] SumHi = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] SumLo = 48'sh8000_0000_0000;

  typedef enum logic [3:0] {
    S_IN, S_CLEAR, S_SLOT_RD, S_SLOT_CHK, S_LEN_CHK, S_CMP_RD, S_CMP_CHK,
    S_UPD_RD, S_UPD, S_NEW, S_COPY_RD, S_COPY_WR, S_OUT
  } state_t;
endpackage

// ----- src/keyed_min_max_mean_aggregator_unit.sv -----
// Top level of the keyed min/max/mean aggregator with its sequencer and memories.
//
//  Channel | Direction | Handshake        | Payload
//  in      | input     | in_valid/ready   | data_byte
//  out     | output    | out_valid/ready  | entry_index, status, min/max/sum/count
//
// A byte that does not end a line is absorbed in S_IN. A newline ending a value starts the
// sequencer: a probe passes S_SLOT_RD and S_SLOT_CHK, plus S_LEN_CHK for an occupied slot;
// equal lengths compare each name byte in S_CMP_RD and S_CMP_CHK, then update in S_UPD_RD
// and S_UPD, while a new entry passes S_NEW, then S_COPY_RD and S_COPY_WR per name byte
// copied. An over-long name goes to the result at once. The result holds in_ready low until
// it is taken. After reset a clearing pass empties the slot table; no request is taken.
module keyed_min_max_mean_aggregator_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 data_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [kmmma_pkg::EntW-1:0] entry_index,
  output logic [1:0]                 status,
  output logic signed [10:0]         min_tenths,
  output logic signed [10:0]         max_tenths,
  output logic signed [47:0]         sum_tenths,
  output logic [31:0]                sample_count
);
  import kmmma_pkg::*;

  // Memories: slot map, per-entry name bytes, and the statistics.
  logic [SlotW-1:0]  slot_mem [HashSlots];
  logic [7:0]        ename_mem [MaxEntries*MaxNameBytes];
  logic [LenW-1:0]   elen_mem [MaxEntries];
  logic [10:0]       emin_mem [MaxEntries];
  logic [10:0]       emax_mem [MaxEntries];
  logic [47:0]       esum_mem [MaxEntries];
  logic [31:0]       ecnt_mem [MaxEntries];
  logic [7:0]        nbuf_mem [MaxNameBytes];

  state_t state, state_next;
  logic             phase_val;
  logic [LenW-1:0]  name_len;
  logic [HashW-1:0] hash;
  logic [9:0]       acc;
  logic             neg;
  logic [SlotW-1:0] used;
  logic [HashW-1:0] probe_h;
  logic [ProbeW-1:0] probes;
  logic [EntW-1:0]  ent;
  logic [NameW-1:0] bi;
  logic [LenW-1:0]  bcnt;

  logic [SlotW-1:0] slot_rd;
  logic [7:0]       ename_rd, nbuf_rd;
  logic [LenW-1:0]  elen_rd;
  logic signed [10:0] emin_rd, emax_rd;
  logic signed [47:0] esum_rd;
  logic [31:0]      ecnt_rd;

  logic signed [10:0] v;
  assign v = neg ? -$signed({1'b0, acc}) : $signed({1'b0, acc});

  logic signed [48:0] sum_ext;
  assign sum_ext = {esum_rd[47], esum_rd} + {{38{v[10]}}, v};

  logic [EntW+NameW-1:0] ename_addr;
  assign ename_addr = {ent, bi};

  logic [9:0] acc10;
  assign acc10 = 10'(({4'd0, acc} * 14'd10 + 14'(data_byte - ChZero)) > 14'd999
                     ? 14'd999 : ({4'd0, acc} * 14'd10 + 14'(data_byte - ChZero)));

  // Sequencer: next state and handshake outputs.
  always_comb begin
    state_next = state;
    in_ready = (state == S_IN);
    out_valid = (state == S_OUT);
    unique case (state)
      S_CLEAR: if (probe_h == HashW'(HashSlots - 1)) state_next = S_IN;
      S_IN: if (in_valid && phase_val && data_byte == ChNl) begin
        state_next = (name_len > LenW'(MaxNameBytes)) ? S_OUT : S_SLOT_RD;
      end
      S_SLOT_RD: state_next = S_SLOT_CHK;
      S_SLOT_CHK: begin
        if (slot_rd != '0) state_next = S_LEN_CHK;
        else if (used >= SlotW'(MaxEntries)) state_next = S_OUT;
        else state_next = S_NEW;
      end
      S_LEN_CHK: begin
        if (elen_rd == name_len) state_next = S_CMP_RD;
        else if (probes == ProbeW'(HashSlots - 1)) state_next = S_OUT;
        else state_next = S_SLOT_RD;
      end
      S_CMP_RD: state_next = (bcnt == name_len) ? S_UPD_RD : S_CMP_CHK;
      S_CMP_CHK: begin
        if (ename_rd == nbuf_rd) state_next = S_CMP_RD;
        else if (probes == ProbeW'(HashSlots - 1)) state_next = S_OUT;
        else state_next = S_SLOT_RD;
      end
      S_UPD_RD: state_next = S_UPD;
      S_UPD: state_next = S_OUT;
      S_NEW: state_next = S_COPY_RD;
      S_COPY_RD: state_next = (bcnt == name_len) ? S_OUT : S_COPY_WR;
      S_COPY_WR: state_next = S_COPY_RD;
      S_OUT: if (out_ready) state_next = S_IN;
      default: state_next = S_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_h <= '0;
      phase_val <= 1'b0;
      name_len <= '0;
      hash <= '0;
      acc <= '0;
      neg <= 1'b0;
      used <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          slot_mem[probe_h] <= '0;
          probe_h <= probe_h + 1'b1;
        end
        S_IN: if (in_valid) begin
          if (!phase_val) begin
            if (data_byte == ChNl) begin
              name_len <= '0; hash <= '0; acc <= '0; neg <= 1'b0;
            end else if (data_byte == ChSemi) begin
              phase_val <= 1'b1;
            end else begin
              if (name_len < LenW'(MaxNameBytes)) nbuf_mem[name_len[NameW-1:0]] <= data_byte;
              if (name_len <= LenW'(MaxNameBytes)) name_len <= name_len + 1'b1;
              hash <= HashW'(hash * 5'd31 + data_byte);
            end
          end else begin
            if (data_byte == ChNl) begin
              if (name_len > LenW'(MaxNameBytes)) begin
                status <= StLong; entry_index <= '0; min_tenths <= '0;
                max_tenths <= '0; sum_tenths <= '0; sample_count <= '0;
              end else begin
                probe_h <= hash; probes <= '0;
              end
            end else if (data_byte == ChMinus) begin
              neg <= 1'b1;
            end else if (data_byte >= ChZero && data_byte <= ChNine) begin
              acc <= acc10;
            end
          end
        end
        S_SLOT_RD: begin
          slot_rd <= slot_mem[probe_h];
        end
        S_SLOT_CHK: begin
          if (slot_rd == '0) begin
            if (used >= SlotW'(MaxEntries)) begin
              status <= StFull; entry_index <= '0; min_tenths <= '0;
              max_tenths <= '0; sum_tenths <= '0; sample_count <= '0;
            end else begin
              ent <= used[EntW-1:0];
            end
          end else begin
            ent <= EntW'(slot_rd - 1'b1);
            elen_rd <= elen_mem[EntW'(slot_rd - 1'b1)];
          end
        end
        S_LEN_CHK: begin
          bi <= '0; bcnt <= '0;
          if (elen_rd != name_len) begin
            probe_h <= probe_h + 1'b1; probes <= probes + 1'b1;
            if (probes == ProbeW'(HashSlots - 1)) begin
              status <= StFull; entry_index <= '0; min_tenths <= '0;
              max_tenths <= '0; sum_tenths <= '0; sample_count <= '0;
            end
          end
        end
        S_CMP_RD: begin
          if (bcnt != name_len) begin
            ename_rd <= ename_mem[ename_addr];
            nbuf_rd <= nbuf_mem[bi];
          end
        end
        S_CMP_CHK: begin
          if (ename_rd == nbuf_rd) begin
            bi <= bi + 1'b1; bcnt <= bcnt + 1'b1;
          end else begin
            probe_h <= probe_h + 1'b1; probes <= probes + 1'b1;
            if (probes == ProbeW'(HashSlots - 1)) begin
              status <= StFull; entry_index <= '0; min_tenths <= '0;
              max_tenths <= '0; sum_tenths <= '0; sample_count <= '0;
            end
          end
        end
        S_UPD_RD: begin
          emin_rd <= emin_mem[ent]; emax_rd <= emax_mem[ent];
          esum_rd <= esum_mem[ent]; ecnt_rd <= ecnt_mem[ent];
        end
        S_UPD: begin
          logic signed [10:0] mn, mx;
          logic signed [47:0] sm;
          logic [31:0] ct;
          mn = (v < emin_rd) ? v : emin_rd;
          mx = (v > emax_rd) ? v : emax_rd;
          sm = (sum_ext > 49'(SumHi)) ? SumHi :
               (sum_ext < 49'(SumLo)) ? SumLo : sum_ext[47:0];
          ct = (ecnt_rd == '1) ? ecnt_rd : ecnt_rd + 1'b1;
          emin_mem[ent] <= mn; emax_mem[ent] <= mx;
          esum_mem[ent] <= sm; ecnt_mem[ent] <= ct;
          status <= StUpdated; entry_index <= ent; min_tenths <= mn;
          max_tenths <= mx; sum_tenths <= sm; sample_count <= ct;
        end
        S_NEW: begin
          slot_mem[probe_h] <= SlotW'(used + 1'b1);
          used <= used + 1'b1;
          elen_mem[ent] <= name_len;
          emin_mem[ent] <= v; emax_mem[ent] <= v;
          esum_mem[ent] <= {{37{v[10]}}, v}; ecnt_mem[ent] <= 32'd1;
          status <= StNew; entry_index <= ent; min_tenths <= v;
          max_tenths <= v; sum_tenths <= {{37{v[10]}}, v}; sample_count <= 32'd1;
          bi <= '0; bcnt <= '0;
        end
        S_COPY_RD: begin
          if (bcnt != name_len) nbuf_rd <= nbuf_mem[bi];
        end
        S_COPY_WR: begin
          ename_mem[ename_addr] <= nbuf_rd;
          bi <= bi + 1'b1; bcnt <= bcnt + 1'b1;
        end
        S_OUT: if (out_ready) begin
          phase_val <= 1'b0; name_len <= '0;
          hash <= '0; acc <= '0; neg <= 1'b0;
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- sim/tb_keyed_min_max_mean_aggregator_unit.sv -----
// Self-checking testbench for the keyed min/max/mean aggregator unit.
module tb_keyed_min_max_mean_aggregator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import kmmma_pkg::*;

  // The decimal point is ignored by the block, so it is not in the package.
  localparam logic [7:0] ChDot = 8'h2e;
  localparam int PoolSize = 40;
  localparam int PoolMaxLen = 12;

  typedef struct {
    int unsigned idx;
    logic [1:0]  st;
    int          mn;
    int          mx;
    longint      sum;
    longint      cnt;
  } agg_result_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [7:0] data_byte;
  logic [EntW-1:0] entry_index;
  logic [1:0] status;
  logic signed [10:0] min_tenths, max_tenths;
  logic signed [47:0] sum_tenths;
  logic [31:0] sample_count;

  keyed_min_max_mean_aggregator_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .entry_index(entry_index), .status(status), .min_tenths(min_tenths),
    .max_tenths(max_tenths), .sum_tenths(sum_tenths), .sample_count(sample_count)
  );

  // Shadow copy of the aggregator: line parser state and the key table.
  bit          in_value;
  byte unsigned line_name[MaxNameBytes];
  int          line_len;
  int unsigned line_hash;
  int          line_acc;
  bit          line_neg;
  int          slot_owner[HashSlots];
  byte unsigned key_name[MaxEntries][MaxNameBytes];
  int          key_len[MaxEntries];
  int          key_min[MaxEntries];
  int          key_max[MaxEntries];
  longint      key_sum[MaxEntries];
  longint      key_cnt[MaxEntries];
  int          keys_used;

  agg_result_t pending_results[$];
  int errors, bytes_sent, lines_done, n_new, n_upd, n_full, n_long;

  // Handshake shaping shared between the stimulus and the result sink.
  bit steady_in, steady_out;
  int sink_hold;

  byte unsigned pool[PoolSize][PoolMaxLen];
  int pool_len[PoolSize];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30ms;
    $display("keyed_min_max_mean_aggregator_unit: mismatch");
    $finish;
  end

  function automatic bit same_key(int e);
    if (key_len[e] != line_len) return 0;
    for (int k = 0; k < line_len; k++)
      if (key_name[e][k] != line_name[k]) return 0;
    return 1;
  endfunction

  // Resolves a completed line against the key table and returns the result.
  function automatic agg_result_t close_line();
    agg_result_t r;
    int v, e;
    int unsigned h;
    bit found_empty;
    r = '{0, StUpdated, 0, 0, 0, 0};
    v = line_neg ? -line_acc : line_acc;
    h = line_hash % HashSlots;
    found_empty = 0;
    if (line_len > MaxNameBytes) begin
      r.st = StLong;
      return r;
    end
    for (int p = 0; p < HashSlots; p++) begin
      if (slot_owner[h] == 0) begin
        found_empty = 1;
        break;
      end
      e = slot_owner[h] - 1;
      if (same_key(e)) begin
        if (v < key_min[e]) key_min[e] = v;
        if (v > key_max[e]) key_max[e] = v;
        key_sum[e] = key_sum[e] + v;
        if (key_sum[e] > longint'(SumHi)) key_sum[e] = SumHi;
        if (key_sum[e] < longint'(SumLo)) key_sum[e] = SumLo;
        if (key_cnt[e] != 64'hFFFF_FFFF) key_cnt[e]++;
        r = '{e, StUpdated, key_min[e], key_max[e], key_sum[e], key_cnt[e]};
        return r;
      end
      h = (h + 1) % HashSlots;
    end
    if (!found_empty || keys_used >= MaxEntries) begin
      r.st = StFull;
      return r;
    end
    e = keys_used;
    for (int k = 0; k < line_len; k++) key_name[e][k] = line_name[k];
    key_len[e] = line_len;
    key_min[e] = v;
    key_max[e] = v;
    key_sum[e] = v;
    key_cnt[e] = 1;
    slot_owner[h] = e + 1;
    keys_used++;
    r = '{e, StNew, v, v, v, 1};
    return r;
  endfunction

  function automatic void reset_line();
    in_value = 0;
    line_len = 0;
    line_hash = 0;
    line_acc = 0;
    line_neg = 0;
  endfunction

  // Advances the shadow parser by one accepted byte.
  function automatic void absorb_byte(byte unsigned b);
    agg_result_t r;
    if (!in_value) begin
      if (b == ChNl) reset_line();
      else if (b == ChSemi) in_value = 1;
      else begin
        if (line_len < MaxNameBytes) line_name[line_len] = b;
        if (line_len <= MaxNameBytes) line_len++;
        line_hash = (line_hash * 31 + b) % HashSlots;
      end
    end else begin
      if (b == ChNl) begin
        r = close_line();
        pending_results.push_back(r);
        lines_done++;
        case (r.st)
          StNew:   n_new++;
          StFull:  n_full++;
          StLong:  n_long++;
          default: n_upd++;
        endcase
        reset_line();
      end else if (b == ChMinus) line_neg = 1;
      else if (b >= ChZero && b <= ChNine) begin
        line_acc = line_acc * 10 + (b - ChZero);
        if (line_acc > 999) line_acc = 999;
      end
    end
  endfunction

  // Offers one request after a random gap and returns at the accepting edge.
  task automatic send_byte(byte unsigned b);
    int gap;
    gap = steady_in ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    absorb_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(string s);
    for (int k = 0; k < s.len(); k++) send_byte(s[k]);
  endtask

  task automatic send_value();
    int nd;
    if ($urandom_range(0, 2) == 0) send_byte(ChMinus);
    nd = $urandom_range(0, 9) == 0 ? $urandom_range(0, 4) : $urandom_range(1, 2);
    repeat (nd) send_byte(8'(ChZero + $urandom_range(0, 9)));
    send_byte(ChDot);
    send_byte(8'(ChZero + $urandom_range(0, 9)));
    send_byte(ChNl);
  endtask

  // Withdraws the offer and waits until every expected result has been taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Result sink: random stalls, plus a long hold-off when one is requested.
  initial begin
    agg_result_t exp_r, got;
    int stall;
    out_ready <= 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      stall = steady_out ? 0 : $urandom_range(0, 19);
      if (sink_hold > 0) begin
        stall = sink_hold;
        sink_hold = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      got = '{entry_index, status, min_tenths, max_tenths, sum_tenths, sample_count};
      @(posedge clk);
      if (pending_results.size() == 0) begin
        $error("result with nothing outstanding: index %0d status %0d", got.idx, got.st);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got.idx != exp_r.idx) begin
          $error("entry_index expected %0d got %0d", exp_r.idx, got.idx);
          errors++;
        end
        if (got.st != exp_r.st) begin
          $error("status expected %0d got %0d", exp_r.st, got.st);
          errors++;
        end
        if (got.mn != exp_r.mn) begin
          $error("min_tenths expected %0d got %0d", exp_r.mn, got.mn);
          errors++;
        end
        if (got.mx != exp_r.mx) begin
          $error("max_tenths expected %0d got %0d", exp_r.mx, got.mx);
          errors++;
        end
        if (got.sum != exp_r.sum) begin
          $error("sum_tenths expected %0d got %0d", exp_r.sum, got.sum);
          errors++;
        end
        if (got.cnt != exp_r.cnt) begin
          $error("sample_count expected %0d got %0d", exp_r.cnt, got.cnt);
          errors++;
        end
      end
    end
  end

  // Extremes of the value, odd bytes in the value, lines cut short, name lengths
  // at and beyond the limit, bytes with the top bit set and a hash collision.
  task automatic test_directed();
    string edge_name;
    send_text("Aa;99.9\n");
    send_text("BB;-99.9\n");          // same hash as the line above
    send_text("Aa;-0.0\n");           // minus zero counts as zero
    send_text("Aa;12;3.4\n");         // second separator is skipped
    send_text("BB;-\n");              // value with no digits
    send_text("Ab;12345.6\n");        // digits saturate at 999
    send_text("lost\n");              // no separator: no result
    send_text("\n");
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(8'h80);
    send_text(";7.7\n");
    send_text("A;5\n");
    edge_name = "";
    repeat (MaxNameBytes) edge_name = {edge_name, "n"};
    send_text({edge_name, ";1.0\n"});
    send_text({edge_name, ";-2.0\n"});
    send_text({edge_name, "n;3.0\n"}); // one byte too long: dropped
    send_text({edge_name, "nnnn;3.0\n"});
  endtask

  // Mostly well-formed lines over a small key pool, with noise and broken lines.
  task automatic test_random(int n_bytes);
    int start, sel, k;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      if ($urandom_range(0, 99) == 0) begin
        steady_in = $urandom_range(0, 3) == 0;
        steady_out = $urandom_range(0, 3) == 0;
      end
      sel = $urandom_range(0, 99);
      if (sel < 80) begin
        k = $urandom_range(0, PoolSize - 1);
        for (int j = 0; j < pool_len[k]; j++) send_byte(pool[k][j]);
        send_byte(ChSemi);
        send_value();
      end else if (sel < 88) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
        send_byte(ChSemi);
        send_value();
      end else if (sel < 95) begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_text("cut");
        send_byte(ChNl);
      end
    end
    steady_in = 0;
    steady_out = 0;
  endtask

  // The sink holds off for a long stretch while lines keep coming, then the
  // source pauses until every result has been taken.
  task automatic test_backpressure();
    steady_in = 1;
    sink_hold = 400;
    repeat (20) send_text("Aa;1.5\n");
    steady_in = 0;
    wait_drained();
  endtask

  // Fills the key table to the limit with short two-byte keys, then offers new
  // keys and a known one.
  task automatic test_table_full();
    steady_in = 1;
    steady_out = 1;
    for (int k = 0; keys_used < MaxEntries; k++) begin
      send_byte(8'(8'h41 + (k >> 5)));
      send_byte(8'(8'h61 + (k & 31)));
      send_byte(ChSemi);
      send_byte(8'(ChZero + k % 10));
      send_byte(ChNl);
    end
    send_text("Zq1;1.0\n");
    send_text("Zq2;-1.0\n");
    send_text("Aa;2.0\n");
    steady_in = 0;
    steady_out = 0;
  endtask

  initial begin
    in_valid <= 1'b0;
    data_byte <= 8'h00;
    rst <= 1'b1;
    steady_in = 0;
    steady_out = 0;
    sink_hold = 0;
    errors = 0;
    bytes_sent = 0;
    lines_done = 0;
    n_new = 0;
    n_upd = 0;
    n_full = 0;
    n_long = 0;
    keys_used = 0;
    reset_line();
    foreach (slot_owner[i]) slot_owner[i] = 0;
    for (int k = 0; k < PoolSize; k++) begin
      pool_len[k] = $urandom_range(1, PoolMaxLen);
      for (int j = 0; j < pool_len[k]; j++) begin
        do pool[k][j] = 8'($urandom_range(1, 255));
        while (pool[k][j] == ChSemi || pool[k][j] == ChNl);
      end
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    wait_drained();
    test_random(400);
    wait_drained();
    test_backpressure();
    test_table_full();
    wait_drained();

    $display("Sent %0d bytes forming %0d lines: %0d new keys, %0d updates,",
             bytes_sent, lines_done, n_new, n_upd);
    $display("%0d dropped on a full table, %0d dropped for over-long names.",
             n_full, n_long);
    if (errors == 0) begin
      $display("keyed_min_max_mean_aggregator_unit: match");
    end else begin
      $display("keyed_min_max_mean_aggregator_unit: mismatch");
    end
    $finish;
  end
endmodule
